[hdl/quoted_string_literal_lexer_top_macros.svh]
// Assertion macros shared by the checker files of the string literal lexer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef QUOTED_STRING_LITERAL_LEXER_TOP_MACROS_SVH
`define QUOTED_STRING_LITERAL_LEXER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QSL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/qsl_pkg.sv]
package qsl_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CONSUMED_W     = 16;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    typedef enum logic [2:0] {
        PH_FILLER = 3'd0,
        PH_LINE   = 3'd1,
        PH_BLOCK  = 3'd2,
        PH_STRING = 3'd3,
        PH_ESCAPE = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_OK     = 3'd1,
        ST_UNESC  = 3'd2,
        ST_NOQ    = 3'd3,
        ST_BADESC = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  out_valid;
        logic                  done_res;
        status_t               status;
        logic [CONSUMED_W-1:0] consumed;
    } res_t;

endpackage

[hdl/qsl_input_stage.sv]
module qsl_input_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       down_ready,
    output logic       item_valid,
    output logic [7:0] item_byte
);
    import qsl_pkg::*;

    logic       item_valid_reg;
    logic       item_valid_next;
    logic [7:0] item_byte_reg;
    logic [7:0] item_byte_next;

    // The held byte blocks new input only when it cannot move on this cycle.
    assign in_stall = item_valid_reg && !down_ready;

    always_comb
    begin
        item_valid_next = in_stall ? 1'b1 : in_valid;
        item_byte_next  = (in_valid && !in_stall) ? text_byte : item_byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_byte_reg <= item_byte_next;
    end

    assign item_valid = item_valid_reg;
    assign item_byte  = item_byte_reg;

endmodule

[hdl/qsl_core.sv]
module qsl_core #(
    parameter int COUNT_BITS = qsl_pkg::COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   b,
    output qsl_pkg::res_t res
);
    import qsl_pkg::*;

    phase_t                phase_reg,  phase_next;
    logic                  pending_slash_reg, pending_slash_next;
    logic                  pending_star_reg,  pending_star_next;
    logic                  double_quoted_reg, double_quoted_next;
    logic                  bad_escape_reg,    bad_escape_next;
    logic [COUNT_BITS-1:0] byte_count_reg,    byte_count_next;

    logic [COUNT_BITS-1:0] cnt_stepped;
    logic                  cnt_over;
    logic [7:0]            close_quote;
    logic                  esc_known;
    logic [7:0]            esc_byte;

    // Saturating count of the bytes in this request, end of text excluded.
    assign cnt_stepped = byte_count_reg
        + COUNT_BITS'((b != CH_END) && (byte_count_reg != {COUNT_BITS{1'b1}}));
    assign cnt_over    = |(cnt_stepped >> CONSUMED_W);
    assign close_quote = double_quoted_reg ? CH_DQUOTE : CH_SQUOTE;

    always_comb
    begin
        esc_known = 1'b1;
        case (b)
            CH_DQUOTE: esc_byte = CH_DQUOTE;
            CH_BSLASH: esc_byte = CH_BSLASH;
            CH_LOW_N:  esc_byte = CH_NL;
            CH_LOW_R:  esc_byte = CH_CR;
            CH_LOW_T:  esc_byte = CH_TAB;
            default:
            begin
                esc_byte  = 8'h00;
                esc_known = 1'b0;
            end
        endcase
    end

    // Result of the current byte.
    always_comb
    begin
        res = '0;
        case (phase_reg)
            PH_LINE, PH_BLOCK:
            begin
                res.done_res = (b == CH_END);
            end
            PH_STRING:
            begin
                if (b == CH_END)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_NOQ;
                end
                else if (b == close_quote)
                begin
                    res.done_res = 1'b1;
                    if (bad_escape_reg)
                    begin
                        res.status = ST_BADESC;
                    end
                    else
                    begin
                        res.status   = ST_OK;
                        res.consumed = cnt_over ? {CONSUMED_W{1'b1}}
                                                : CONSUMED_W'(cnt_stepped);
                    end
                end
                else if (!(double_quoted_reg && b == CH_BSLASH))
                begin
                    res.out_byte  = b;
                    res.out_valid = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                if (b == CH_END)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_UNESC;
                end
                else
                begin
                    res.out_byte  = esc_byte;
                    res.out_valid = esc_known;
                end
            end
            default:
            begin
                if (pending_slash_reg)
                begin
                    res.done_res = !(b inside {CH_STAR, CH_SLASH});
                end
                else
                begin
                    res.done_res =
                        !(b inside {CH_SPACE, CH_NL, CH_SLASH, CH_DQUOTE, CH_SQUOTE});
                end
            end
        endcase
    end

    // Next lexer state.
    always_comb
    begin
        phase_next         = phase_reg;
        pending_slash_next = pending_slash_reg;
        pending_star_next  = pending_star_reg;
        double_quoted_next = double_quoted_reg;
        bad_escape_next    = bad_escape_reg;
        byte_count_next    = cnt_stepped;
        case (phase_reg)
            PH_LINE:
            begin
                if (b == CH_NL)
                begin
                    phase_next = PH_FILLER;
                end
            end
            PH_BLOCK:
            begin
                if (pending_star_reg && b == CH_SLASH)
                begin
                    phase_next        = PH_FILLER;
                    pending_star_next = 1'b0;
                end
                else
                begin
                    pending_star_next = (b == CH_STAR);
                end
            end
            PH_STRING:
            begin
                if (double_quoted_reg && b == CH_BSLASH)
                begin
                    phase_next = PH_ESCAPE;
                end
            end
            PH_ESCAPE:
            begin
                phase_next = PH_STRING;
                if (!esc_known)
                begin
                    bad_escape_next = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_FILLER;
                if (pending_slash_reg)
                begin
                    pending_slash_next = 1'b0;
                    if (b == CH_STAR)
                    begin
                        phase_next        = PH_BLOCK;
                        pending_star_next = 1'b0;
                    end
                    else if (b == CH_SLASH)
                    begin
                        phase_next = PH_LINE;
                    end
                end
                else if (b == CH_SLASH)
                begin
                    pending_slash_next = 1'b1;
                end
                else if (b == CH_DQUOTE || b == CH_SQUOTE)
                begin
                    phase_next         = PH_STRING;
                    double_quoted_next = (b == CH_DQUOTE);
                    bad_escape_next    = 1'b0;
                end
            end
        endcase
        if (res.done_res)
        begin
            phase_next         = PH_FILLER;
            pending_slash_next = 1'b0;
            pending_star_next  = 1'b0;
            double_quoted_next = 1'b0;
            bad_escape_next    = 1'b0;
            byte_count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_FILLER;
            pending_slash_reg <= 1'b0;
            pending_star_reg  <= 1'b0;
            double_quoted_reg <= 1'b0;
            bad_escape_reg    <= 1'b0;
            byte_count_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            pending_slash_reg <= pending_slash_next;
            pending_star_reg  <= pending_star_next;
            double_quoted_reg <= double_quoted_next;
            bad_escape_reg    <= bad_escape_next;
            byte_count_reg    <= byte_count_next;
        end
    end

endmodule

[hdl/qsl_result_stage.sv]
module qsl_result_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  qsl_pkg::res_t               res_in,
    output logic                        ready,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [7:0]                  out_byte,
    output logic                        out_valid,
    output logic                        done_res,
    output logic [2:0]                  status,
    output logic [qsl_pkg::CONSUMED_W-1:0] consumed
);
    import qsl_pkg::*;

    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;
    res_t res_next;

    // The register can take a new beat when it is empty or being drained.
    assign ready = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_valid_next = load ? 1'b1 : (res_valid_reg && res_stall);
        res_next       = load ? res_in : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign out_byte  = res_reg.out_byte;
    assign out_valid = res_reg.out_valid;
    assign done_res  = res_reg.done_res;
    assign status    = 3'(res_reg.status);
    assign consumed  = res_reg.consumed;

endmodule

[hdl/quoted_string_literal_lexer_top.sv]
// Channel   Handshake            Payload
// input     in_valid / in_stall  text_byte
// result    res_valid/ res_stall out_byte, out_valid, done_res, status, consumed
//
// One byte is accepted every cycle while in_stall is low, and every byte yields
// exactly one result beat. An accepted byte is held in the input register, then
// passes through the lexer update into the result register, where its result beat
// stays on the result port until it is taken.
// rst_n clears all lexer state and both valid flags asynchronously.
// A stalled result holds its beat; the input register still takes one more byte,
// and in_stall rises only while that byte waits behind the stalled result.
module quoted_string_literal_lexer_top #(
    parameter int COUNT_BITS = qsl_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     text_byte,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [7:0]                     out_byte,
    output logic                           out_valid,
    output logic                           done_res,
    output logic [2:0]                     status,
    output logic [qsl_pkg::CONSUMED_W-1:0] consumed
);
    import qsl_pkg::*;

    logic       res_ready;
    logic       item_valid;
    logic [7:0] item_byte;
    logic       step;
    res_t       core_res;

    // The lexer state advances exactly when the held byte moves into the
    // result register, so each byte updates the state once.
    assign step = item_valid && res_ready;

    qsl_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .down_ready (res_ready),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    // Filler skipping, comment tracking, quote matching and escape decoding.
    qsl_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .b     (item_byte),
        .res   (core_res)
    );

    qsl_result_stage u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res_in    (core_res),
        .ready     (res_ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .done_res  (done_res),
        .status    (status),
        .consumed  (consumed)
    );

endmodule

[hdl/qsl_checker.sv]
`include "quoted_string_literal_lexer_top_macros.svh"

module qsl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           res_valid,
    input logic                           res_stall,
    input logic [7:0]                     out_byte,
    input logic                           out_valid,
    input logic                           done_res,
    input logic [2:0]                     status,
    input logic [qsl_pkg::CONSUMED_W-1:0] consumed
);
    import qsl_pkg::*;

    // A stalled result beat must hold still.
    `QSL_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(out_byte) && $stable(done_res) && $stable(status) && $stable(consumed), "result beat changed while stalled")

    // The input only stalls behind a stalled result beat.
    `QSL_ASSERT_NOW(a_in_stall_cause, in_stall, res_valid && res_stall, "input stalled without a stalled result")

    // A beat never both emits content and ends the request.
    `QSL_ASSERT_NOW(a_emit_or_done, res_valid, !(out_valid && done_res), "content byte on the ending beat")

    // Status is only reported on the ending beat.
    `QSL_ASSERT_NOW(a_status_done, res_valid && !done_res, status == ST_NONE, "status without end of request")

    // A nonzero byte count appears only with a good closing quote.
    `QSL_ASSERT_NOW(a_consumed_ok, res_valid && consumed != '0, done_res && status == ST_OK, "count reported without ok status")

endmodule

bind quoted_string_literal_lexer_top qsl_checker u_qsl_checker (.*);

[tb/sv/tb_quoted_string_literal_lexer_top.sv]
// Testbench for the quoted string literal lexer.
//
// Every text byte accepted on the input channel yields exactly one result beat,
// so the expected beats form a simple in-order queue. A behavioral lexer in this
// module tracks its own copy of the request state and computes the beat for each
// accepted byte. A directed table opens the run, then randomly built requests
// follow, with a calm stretch in the middle where neither side idles.
module tb_quoted_string_literal_lexer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import qsl_pkg::*;

    // Cycles without any accepted beat on either channel before the run is
    // declared hung. Random gaps on both sides are short and rare, so this
    // is far above any correct run.
    localparam int HANG_LIMIT = 2000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [7:0]            text_byte = 8'h00;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [7:0]            out_byte;
    logic                  out_valid;
    logic                  done_res;
    logic [2:0]            status;
    logic [CONSUMED_W-1:0] consumed;

    quoted_string_literal_lexer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .done_res  (done_res),
        .status    (status),
        .consumed  (consumed)
    );

    always #5ns clk = ~clk;

    // One row of the directed table. Rows with hand_checked set carry the beat
    // typed in below; the others are checked against the behavioral lexer.
    typedef struct packed {
        logic [7:0]            text;
        logic                  hand_checked;
        logic [7:0]            e_byte;
        logic                  e_valid;
        logic                  e_done;
        status_t               e_status;
        logic [CONSUMED_W-1:0] e_consumed;
    } dir_row_t;

    dir_row_t directed_text [29] = '{
        // A stray letter right after reset ends the request with no string.
        '{8'h41,     1'b1, 8'h00, 1'b0, 1'b1, ST_NONE,   16'd0},
        // End of text before any string.
        '{CH_END,    1'b1, 8'h00, 1'b0, 1'b1, ST_NONE,   16'd0},
        '{CH_SPACE,  1'b1, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_NL,     1'b1, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        // Line comment up to the newline.
        '{CH_SLASH,  1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_SLASH,  1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{8'h78,     1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_NL,     1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        // Block comment holding a second opener that must be ignored.
        '{CH_SLASH,  1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_STAR,   1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_SLASH,  1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_STAR,   1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_STAR,   1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_SLASH,  1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        // Double-quoted string: a newline escape, an unknown escape, the top
        // byte value, and the closing quote reporting the unknown escape.
        '{CH_DQUOTE, 1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_BSLASH, 1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_LOW_N,  1'b1, CH_NL, 1'b1, 1'b0, ST_NONE,   16'd0},
        '{CH_BSLASH, 1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{8'h71,     1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{8'hFF,     1'b1, 8'hFF, 1'b1, 1'b0, ST_NONE,   16'd0},
        '{CH_DQUOTE, 1'b1, 8'h00, 1'b0, 1'b1, ST_BADESC, 16'd0},
        // Single-quoted string takes a backslash literally.
        '{CH_SQUOTE, 1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_BSLASH, 1'b1, CH_BSLASH, 1'b1, 1'b0, ST_NONE, 16'd0},
        '{CH_SQUOTE, 1'b1, 8'h00, 1'b0, 1'b1, ST_OK,     16'd3},
        // A lone slash swallows the byte after it.
        '{CH_SLASH,  1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{8'h6B,     1'b1, 8'h00, 1'b0, 1'b1, ST_NONE,   16'd0},
        // End of text right after a backslash.
        '{CH_DQUOTE, 1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_BSLASH, 1'b0, 8'h00, 1'b0, 1'b0, ST_NONE,   16'd0},
        '{CH_END,    1'b1, 8'h00, 1'b0, 1'b1, ST_UNESC,  16'd0}
    };

    // Behavioral lexer state, a single copy that is cleared at the end of each request.
    phase_t                    lx_phase  = PH_FILLER;
    logic                      lx_slash  = 1'b0;
    logic                      lx_star   = 1'b0;
    logic                      lx_dq     = 1'b0;
    logic                      lx_bad    = 1'b0;
    logic [COUNT_BITS_DEF-1:0] lx_count  = '0;

    res_t        lexer_results_due [$];
    logic [7:0]  text_pending [$];
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          bytes_fed = 0;
    int          random_bytes = 0;
    int          beats_seen = 0;
    int          content_seen = 0;
    int          requests_closed [0:7];
    int          hang_cycles = 0;
    res_t        want_beat;

    // Advances the behavioral lexer by one text byte and returns the beat the
    // block must produce for it.
    function automatic res_t lex_decode_byte(input logic [7:0] b);
        res_t r;
        r = '0;
        if (b != CH_END && lx_count != '1)
            lx_count = lx_count + 1'b1;
        case (lx_phase)
            PH_LINE:
            begin
                if (b == CH_END)
                    r.done_res = 1'b1;
                else if (b == CH_NL)
                    lx_phase = PH_FILLER;
            end
            PH_BLOCK:
            begin
                if (b == CH_END)
                    r.done_res = 1'b1;
                else if (lx_star && b == CH_SLASH)
                begin
                    lx_phase = PH_FILLER;
                    lx_star  = 1'b0;
                end
                else
                    lx_star = (b == CH_STAR);
            end
            PH_STRING:
            begin
                if (b == CH_END)
                begin
                    r.done_res = 1'b1;
                    r.status   = ST_NOQ;
                end
                else if (b == (lx_dq ? CH_DQUOTE : CH_SQUOTE))
                begin
                    r.done_res = 1'b1;
                    if (lx_bad)
                        r.status = ST_BADESC;
                    else
                    begin
                        r.status   = ST_OK;
                        r.consumed = CONSUMED_W'(lx_count);
                    end
                end
                else if (lx_dq && b == CH_BSLASH)
                    lx_phase = PH_ESCAPE;
                else
                begin
                    r.out_byte  = b;
                    r.out_valid = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                if (b == CH_END)
                begin
                    r.done_res = 1'b1;
                    r.status   = ST_UNESC;
                end
                else
                begin
                    lx_phase    = PH_STRING;
                    r.out_valid = 1'b1;
                    case (b)
                        CH_DQUOTE: r.out_byte = CH_DQUOTE;
                        CH_BSLASH: r.out_byte = CH_BSLASH;
                        CH_LOW_N:  r.out_byte = CH_NL;
                        CH_LOW_R:  r.out_byte = CH_CR;
                        CH_LOW_T:  r.out_byte = CH_TAB;
                        default:
                        begin
                            r.out_valid = 1'b0;
                            lx_bad      = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                lx_phase = PH_FILLER;
                if (lx_slash)
                begin
                    lx_slash = 1'b0;
                    if (b == CH_STAR)
                    begin
                        lx_phase = PH_BLOCK;
                        lx_star  = 1'b0;
                    end
                    else if (b == CH_SLASH)
                        lx_phase = PH_LINE;
                    else
                        r.done_res = 1'b1;
                end
                else if (b == CH_SPACE || b == CH_NL)
                    ;
                else if (b == CH_SLASH)
                    lx_slash = 1'b1;
                else if (b == CH_DQUOTE || b == CH_SQUOTE)
                begin
                    lx_phase = PH_STRING;
                    lx_dq    = (b == CH_DQUOTE);
                    lx_bad   = 1'b0;
                end
                else
                    r.done_res = 1'b1;
            end
        endcase
        if (r.done_res)
        begin
            lx_phase = PH_FILLER;
            lx_slash = 1'b0;
            lx_star  = 1'b0;
            lx_dq    = 1'b0;
            lx_bad   = 1'b0;
            lx_count = '0;
        end
        return r;
    endfunction

    function automatic logic [7:0] any_text_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // Appends one random request to the pending text. Most requests are well
    // formed (filler, a quoted string with escapes, a closing quote); the rest
    // are truncated or plain noise that lands the lexer in odd states.
    function automatic void queue_request();
        int         kind;
        int         n;
        logic [7:0] close_q;
        logic [7:0] b;
        bit         dq;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0: b = CH_END;
                    1: b = CH_SPACE;
                    2: b = CH_NL;
                    3: b = CH_SLASH;
                    4: b = CH_STAR;
                    5: b = CH_DQUOTE;
                    6: b = CH_SQUOTE;
                    7: b = CH_BSLASH;
                    8: b = CH_LOW_N;
                    default: b = any_text_byte();
                endcase
                text_pending.push_back(b);
            end
            return;
        end
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    repeat ($urandom_range(1, 3))
                        text_pending.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NL);
                end
                1:
                begin
                    text_pending.push_back(CH_SLASH);
                    text_pending.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 6))
                    begin
                        do
                            b = any_text_byte();
                        while (b == CH_NL);
                        text_pending.push_back(b);
                    end
                    // Now and then the text ends inside the comment.
                    if ($urandom_range(0, 99) < 8)
                    begin
                        text_pending.push_back(CH_END);
                        return;
                    end
                    text_pending.push_back(CH_NL);
                end
                default:
                begin
                    text_pending.push_back(CH_SLASH);
                    text_pending.push_back(CH_STAR);
                    repeat ($urandom_range(0, 6))
                        text_pending.push_back($urandom_range(0, 3) == 0 ? CH_STAR
                                                                         : any_text_byte());
                    if ($urandom_range(0, 99) < 8)
                    begin
                        text_pending.push_back(CH_END);
                        return;
                    end
                    text_pending.push_back(CH_STAR);
                    text_pending.push_back(CH_SLASH);
                end
            endcase
        end
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            // A lone slash, followed by end of text or a byte it swallows.
            text_pending.push_back(CH_SLASH);
            do
                b = $urandom_range(0, 1) ? CH_END : any_text_byte();
            while (b == CH_SLASH || b == CH_STAR);
            text_pending.push_back(b);
            return;
        end
        if (kind < 10)
        begin
            do
                b = $urandom_range(0, 3) == 0 ? CH_END : any_text_byte();
            while (b inside {CH_SPACE, CH_NL, CH_SLASH, CH_DQUOTE, CH_SQUOTE});
            text_pending.push_back(b);
            return;
        end
        dq      = 1'($urandom_range(0, 1));
        close_q = dq ? CH_DQUOTE : CH_SQUOTE;
        text_pending.push_back(close_q);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        repeat (n)
        begin
            if (dq && $urandom_range(0, 99) < 35)
            begin
                text_pending.push_back(CH_BSLASH);
                case ($urandom_range(0, 6))
                    0: b = CH_DQUOTE;
                    1: b = CH_BSLASH;
                    2: b = CH_LOW_N;
                    3: b = CH_LOW_R;
                    4: b = CH_LOW_T;
                    default: b = any_text_byte();
                endcase
                text_pending.push_back(b);
            end
            else
            begin
                do
                    b = (!dq && $urandom_range(0, 7) == 0) ? CH_BSLASH : any_text_byte();
                while (b == close_q || (dq && b == CH_BSLASH));
                text_pending.push_back(b);
            end
        end
        kind = $urandom_range(0, 99);
        if (kind < 85)
            text_pending.push_back(close_q);
        else if (kind < 93 || !dq)
            text_pending.push_back(CH_END);
        else
        begin
            text_pending.push_back(CH_BSLASH);
            text_pending.push_back(CH_END);
        end
    endfunction

    // Presents one byte until it is accepted and returns the beat it must
    // produce. Outside calm stretches the sender now and then holds back first.
    // Each branch makes at most one assignment to in_valid per clock edge, so a
    // valid that stays high is never dropped and raised in the same time step.
    task automatic send_text_byte(input logic [7:0] b, output res_t beat);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beat = lex_decode_byte(b);
        bytes_fed++;
    endtask

    task automatic feed_byte(input logic [7:0] b);
        res_t beat;
        send_text_byte(b, beat);
        lexer_results_due.push_back(beat);
    endtask

    // Feeds random requests until the target count is reached and the last
    // request built has been sent whole.
    task automatic drive_random_text(input int target);
        while (random_bytes < target || text_pending.size() != 0)
        begin
            if (text_pending.size() == 0)
                queue_request();
            feed_byte(text_pending.pop_front());
            random_bytes++;
        end
    endtask

    // The receiver stalls at random, except during the calm stretch.
    always @(posedge clk)
        res_stall <= !calm && ($urandom_range(0, 99) < 11);

    // Result checker: every accepted beat is matched against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            beats_seen++;
            if (lexer_results_due.size() == 0)
            begin
                $error("result beat with no expectation pending");
                mismatches++;
            end
            else
            begin
                want_beat = lexer_results_due.pop_front();
                if (out_byte !== want_beat.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want_beat.out_byte, out_byte);
                    mismatches++;
                end
                if (out_valid !== want_beat.out_valid)
                begin
                    $error("out_valid: expected %b, got %b", want_beat.out_valid, out_valid);
                    mismatches++;
                end
                if (done_res !== want_beat.done_res)
                begin
                    $error("done_res: expected %b, got %b", want_beat.done_res, done_res);
                    mismatches++;
                end
                if (status !== 3'(want_beat.status))
                begin
                    $error("status: expected %0d, got %0d", want_beat.status, status);
                    mismatches++;
                end
                if (consumed !== want_beat.consumed)
                begin
                    $error("consumed: expected %0d, got %0d", want_beat.consumed, consumed);
                    mismatches++;
                end
                if (want_beat.done_res)
                    requests_closed[want_beat.status]++;
                if (want_beat.out_valid)
                    content_seen++;
            end
        end
    end

    // Hang detection: a long run of cycles with no beat accepted on either
    // channel means the block has locked up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (res_valid && !res_stall))
                hang_cycles <= 0;
            else if (hang_cycles >= HANG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                hang_cycles <= hang_cycles + 1;
        end
    end

    initial
    begin
        res_t beat;
        res_t typed_beat;
        foreach (requests_closed[k])
            requests_closed[k] = 0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Hand-checked rows push the typed beat; the lexer
        // model still advances on them so that later rows stay in step.
        foreach (directed_text[i])
        begin
            send_text_byte(directed_text[i].text, beat);
            if (directed_text[i].hand_checked)
            begin
                typed_beat.out_byte  = directed_text[i].e_byte;
                typed_beat.out_valid = directed_text[i].e_valid;
                typed_beat.done_res  = directed_text[i].e_done;
                typed_beat.status    = directed_text[i].e_status;
                typed_beat.consumed  = directed_text[i].e_consumed;
                lexer_results_due.push_back(typed_beat);
            end
            else
                lexer_results_due.push_back(beat);
        end

        drive_random_text(350);

        // Calm stretch with no gaps on either side, so bytes and result beats
        // run back to back.
        calm = 1'b1;
        drive_random_text(500);
        calm = 1'b0;

        drive_random_text(700);
        in_valid <= 1'b0;

        // Drain: wait for every expected beat, then keep clocking to catch any extra beat.
        while (lexer_results_due.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);

        $display("Fed %0d text bytes (%0d random) and checked %0d result beats, %0d content.",
                 bytes_fed, random_bytes, beats_seen, content_seen);
        $display("Requests closed: ok %0d, no string %0d, unknown escape %0d, %s %0d, %s %0d.",
                 requests_closed[ST_OK], requests_closed[ST_NONE],
                 requests_closed[ST_BADESC], "missing quote", requests_closed[ST_NOQ],
                 "unterminated escape", requests_closed[ST_UNESC]);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
